>>> hw/rtl/sorted_keyed_table_insert_assert.svh
// Assertion macros shared by the checker of the sorted keyed table.
`ifndef SORTED_KEYED_TABLE_INSERT_ASSERT_SVH
`define SORTED_KEYED_TABLE_INSERT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SKTI_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition in one cycle that requires another in the next cycle.
`define SKTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/skti_pkg.sv
// Types and constants shared by the sorted keyed table modules.
`default_nettype none

package skti_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;

	// Transaction kinds on the command port.
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	// One stored record; the key is host_id, win_start, window_id in that order.
	typedef struct packed {
		logic [63:0] host_id;
		logic [31:0] win_start;
		logic [63:0] window_id;
		logic [63:0] host_window_id;
		logic [31:0] host_start;
		logic        host_type;
		logic        host_status;
		logic        window_type;
	} rec_t;

	// Which result the datapath loads into its output registers.
	typedef enum logic [2:0] {
		EMIT_OFF     = 3'd0,
		EMIT_NONE    = 3'd1,
		EMIT_CLEAR   = 3'd2,
		EMIT_RD_HIT  = 3'd3,
		EMIT_RD_MISS = 3'd4,
		EMIT_EXIST   = 3'd5,
		EMIT_FULL    = 3'd6,
		EMIT_INS     = 3'd7
	} emit_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load;
		logic  rd_mid;
		logic  rd_lo;
		logic  rd_idx;
		logic  step;
		logic  shift_init;
		logic  shift;
		logic  drain;
		logic  insert;
		emit_t emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  ridx_ok;
		logic  lo_lt_hi;
		logic  key_eq;
		logic  lo_lt_cnt;
		logic  tbl_full;
		logic  cnt_gt_lo;
		logic  shift_last;
	} sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/skti_datapath.sv
// Datapath of the sorted keyed table: record memory, search bounds and result registers.
`default_nettype none

module skti_datapath #(
	parameter int unsigned TABLE_DEPTH = skti_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         kind,
	input  logic [5:0]         read_index,
	input  logic [63:0]        host_id,
	input  logic [31:0]        win_start,
	input  logic [63:0]        window_id,
	input  logic               window_type,
	input  logic [63:0]        host_window_id,
	input  logic               host_status,
	input  logic               host_type,
	input  logic [31:0]        host_start,
	input  skti_pkg::cmd_t     cmd,
	output skti_pkg::sts_t     sts,
	output logic               done,
	output logic [6:0]         slot,
	output logic               existed,
	output logic               table_full,
	output logic [6:0]         entry_count,
	output skti_pkg::rec_t     out_rec
);
	import skti_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned XW = ((CW > 6) ? CW : 6) + 1;
	localparam int unsigned KW = 160;

	// Captured transaction.
	kind_t       kind_q;
	logic [5:0]  ridx_q;
	rec_t        new_q;

	// Count, search bounds and shift pointers.
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] wa_q;
	logic          wv_q;

	// Record memory with a registered read port.
	rec_t mem [TABLE_DEPTH];
	rec_t rd_q;

	// Result registers.
	logic       done_q;
	logic [6:0] slot_q;
	logic       existed_q;
	logic       full_q;
	logic [6:0] count_q;
	rec_t       out_rec_q;

	logic [CW-1:0] mid;
	logic [CW-1:0] mid_inc;
	logic [CW-1:0] lo_inc;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] k_dec;
	logic [XW-1:0] ridx_ext;
	logic [XW-1:0] cnt_ext;
	logic [XW-1:0] cnt_inc_ext;
	logic [XW-1:0] lo_ext;
	logic [KW-1:0] key_new;
	logic [KW-1:0] key_rd;
	logic [AW-1:0] ra;
	logic          re;
	logic [AW-1:0] wa;
	logic          we;
	rec_t          wd;

	// Index arithmetic.
	assign mid         = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_inc     = mid + CW'(1);
	assign lo_inc      = lo_q + CW'(1);
	assign cnt_inc     = cnt_q + CW'(1);
	assign k_dec       = k_q - CW'(1);
	assign ridx_ext    = {{(XW-6){1'b0}}, ridx_q};
	assign cnt_ext     = {{(XW-CW){1'b0}}, cnt_q};
	assign cnt_inc_ext = {{(XW-CW){1'b0}}, cnt_inc};
	assign lo_ext      = {{(XW-CW){1'b0}}, lo_q};

	// Keys compare as one unsigned word, host id most significant.
	assign key_new = {new_q.host_id, new_q.win_start, new_q.window_id};
	assign key_rd  = {rd_q.host_id, rd_q.win_start, rd_q.window_id};

	// Status toward the controller.
	assign sts.kind       = kind_q;
	assign sts.ridx_ok    = ridx_ext < cnt_ext;
	assign sts.lo_lt_hi   = lo_q < hi_q;
	assign sts.key_eq     = key_rd == key_new;
	assign sts.lo_lt_cnt  = lo_q < cnt_q;
	assign sts.tbl_full   = cnt_q >= CW'(TABLE_DEPTH);
	assign sts.cnt_gt_lo  = cnt_q > lo_q;
	assign sts.shift_last = k_q == lo_inc;

	// Read address selection.
	always_comb begin
		ra = '0;
		re = 1'b1;
		if (cmd.rd_mid) begin
			ra = mid[AW-1:0];
		end else if (cmd.rd_lo) begin
			ra = lo_q[AW-1:0];
		end else if (cmd.rd_idx) begin
			ra = ridx_ext[AW-1:0];
		end else if (cmd.shift) begin
			ra = k_dec[AW-1:0];
		end else begin
			re = 1'b0;
		end
	end

	// Write port: moved entries during the shift, then the new record.
	assign we = (cmd.shift && wv_q) || cmd.drain || cmd.insert;
	assign wa = cmd.insert ? lo_q[AW-1:0] : wa_q;
	assign wd = cmd.insert ? new_q : rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	// Captured transaction fields.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q                 <= kind_t'(kind);
			ridx_q                 <= read_index;
			new_q.host_id          <= host_id;
			new_q.win_start        <= win_start;
			new_q.window_id        <= window_id;
			new_q.host_window_id   <= host_window_id;
			new_q.host_start       <= host_start;
			new_q.host_type        <= host_type;
			new_q.host_status      <= host_status;
			new_q.window_type      <= window_type;
		end
	end

	// Count, search bounds and shift pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
			k_q    <= '0;
			wa_q   <= '0;
			wv_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit != EMIT_OFF;
			if (cmd.load) begin
				lo_q <= '0;
				hi_q <= cnt_q;
			end
			if (cmd.step) begin
				if (key_rd < key_new) begin
					lo_q <= mid_inc;
				end else begin
					hi_q <= mid;
				end
			end
			if (cmd.shift_init) begin
				k_q  <= cnt_q;
				wv_q <= 1'b0;
			end
			if (cmd.shift) begin
				k_q  <= k_dec;
				wa_q <= k_q[AW-1:0];
				wv_q <= 1'b1;
			end
			if (cmd.insert) begin
				cnt_q <= cnt_inc;
			end
			if (cmd.emit == EMIT_CLEAR) begin
				cnt_q <= '0;
			end
		end
	end

	// Result registers, loaded once per transaction.
	always_ff @(posedge clk) begin
		case (cmd.emit)
			EMIT_OFF: begin
			end
			EMIT_NONE: begin
				slot_q    <= '0;
				existed_q <= 1'b0;
				full_q    <= 1'b0;
				count_q   <= cnt_ext[6:0];
				out_rec_q <= '0;
			end
			EMIT_CLEAR: begin
				slot_q    <= '0;
				existed_q <= 1'b0;
				full_q    <= 1'b0;
				count_q   <= '0;
				out_rec_q <= '0;
			end
			EMIT_RD_HIT: begin
				slot_q    <= ridx_ext[6:0];
				existed_q <= 1'b1;
				full_q    <= 1'b0;
				count_q   <= cnt_ext[6:0];
				out_rec_q <= rd_q;
			end
			EMIT_RD_MISS: begin
				slot_q    <= ridx_ext[6:0];
				existed_q <= 1'b0;
				full_q    <= 1'b0;
				count_q   <= cnt_ext[6:0];
				out_rec_q <= '0;
			end
			EMIT_EXIST: begin
				slot_q    <= lo_ext[6:0];
				existed_q <= 1'b1;
				full_q    <= 1'b0;
				count_q   <= cnt_ext[6:0];
				out_rec_q <= rd_q;
			end
			EMIT_FULL: begin
				slot_q    <= lo_ext[6:0];
				existed_q <= 1'b0;
				full_q    <= 1'b1;
				count_q   <= cnt_ext[6:0];
				out_rec_q <= '0;
			end
			EMIT_INS: begin
				slot_q    <= lo_ext[6:0];
				existed_q <= 1'b0;
				full_q    <= 1'b0;
				count_q   <= cnt_inc_ext[6:0];
				out_rec_q <= new_q;
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign slot        = slot_q;
	assign existed     = existed_q;
	assign table_full  = full_q;
	assign entry_count = count_q;
	assign out_rec     = out_rec_q;

endmodule

`default_nettype wire

>>> hw/rtl/skti_ctrl.sv
// Controller state machine of the sorted keyed table.
`default_nettype none

module skti_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  skti_pkg::sts_t sts,
	output skti_pkg::cmd_t cmd,
	output logic           busy
);
	import skti_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DISP   = 9'b000000010,
		ST_SRCH   = 9'b000000100,
		ST_CMP    = 9'b000001000,
		ST_CHECK  = 9'b000010000,
		ST_SHIFT  = 9'b000100000,
		ST_DRAIN  = 9'b001000000,
		ST_INSERT = 9'b010000000,
		ST_RDWAIT = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign busy = state_q != ST_IDLE;

	// Next state and datapath commands.
	always_comb begin
		cmd       = '0;
		cmd.emit  = EMIT_OFF;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.kind)
					KIND_INSERT: begin
						state_nxt = ST_SRCH;
					end
					KIND_CLEAR: begin
						cmd.emit  = EMIT_CLEAR;
						state_nxt = ST_IDLE;
					end
					KIND_READ: begin
						if (sts.ridx_ok) begin
							cmd.rd_idx = 1'b1;
							state_nxt  = ST_RDWAIT;
						end else begin
							cmd.emit  = EMIT_RD_MISS;
							state_nxt = ST_IDLE;
						end
					end
					default: begin
						cmd.emit  = EMIT_NONE;
						state_nxt = ST_IDLE;
					end
				endcase
			end
			// One probe: read the middle entry, then narrow the bounds; once they meet, read the found slot.
			ST_SRCH: begin
				if (sts.lo_lt_hi) begin
					cmd.rd_mid = 1'b1;
					state_nxt  = ST_CMP;
				end else begin
					cmd.rd_lo = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CMP: begin
				cmd.step  = 1'b1;
				state_nxt = ST_SRCH;
			end
			// The entry at the found slot decides between hit, full and insert.
			ST_CHECK: begin
				if (sts.lo_lt_cnt && sts.key_eq) begin
					cmd.emit  = EMIT_EXIST;
					state_nxt = ST_IDLE;
				end else if (sts.tbl_full) begin
					cmd.emit  = EMIT_FULL;
					state_nxt = ST_IDLE;
				end else if (sts.cnt_gt_lo) begin
					cmd.shift_init = 1'b1;
					state_nxt      = ST_SHIFT;
				end else begin
					state_nxt = ST_INSERT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.drain = 1'b1;
				state_nxt = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				cmd.emit   = EMIT_INS;
				state_nxt  = ST_IDLE;
			end
			ST_RDWAIT: begin
				cmd.emit  = EMIT_RD_HIT;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_keyed_table_insert.sv
// Top level of the sorted keyed table with insert-if-absent.
// Each transaction is taken when start is high and busy is low; its single result
// appears for exactly one cycle with done high and cannot be held off. Records stay
// sorted by host id, start time and window id in one memory with one write port and
// one registered read port, and that port sets the timing: a clear or a read past the
// count is answered from dispatch, a read within the count after its memory read, an
// insert after its search probes (about log2 of the count plus one) and the check of
// the found slot; a new key is then written, after the entries behind it have moved
// up, one per cycle. busy stays high from acceptance until the result is shown.
`default_nettype none

module sorted_keyed_table_insert #(
	parameter int unsigned TABLE_DEPTH = skti_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [5:0]  read_index,
	input  logic [63:0] host_id,
	input  logic [31:0] win_start,
	input  logic [63:0] window_id,
	input  logic        window_type,
	input  logic [63:0] host_window_id,
	input  logic        host_status,
	input  logic        host_type,
	input  logic [31:0] host_start,
	output logic        done,
	output logic [6:0]  slot,
	output logic        existed,
	output logic        table_full,
	output logic [6:0]  entry_count,
	output logic [63:0] out_host_id,
	output logic [31:0] out_win_start,
	output logic [63:0] out_window_id,
	output logic        out_window_type,
	output logic [63:0] out_host_window_id,
	output logic        out_host_status,
	output logic        out_host_type,
	output logic [31:0] out_host_start
);
	import skti_pkg::*;

	cmd_t cmd;
	sts_t sts;
	rec_t out_rec;

	skti_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	skti_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.read_index     (read_index),
		.host_id        (host_id),
		.win_start      (win_start),
		.window_id      (window_id),
		.window_type    (window_type),
		.host_window_id (host_window_id),
		.host_status    (host_status),
		.host_type      (host_type),
		.host_start     (host_start),
		.cmd            (cmd),
		.sts            (sts),
		.done           (done),
		.slot           (slot),
		.existed        (existed),
		.table_full     (table_full),
		.entry_count    (entry_count),
		.out_rec        (out_rec)
	);

	// Unpack the result record onto its ports.
	assign out_host_id        = out_rec.host_id;
	assign out_win_start      = out_rec.win_start;
	assign out_window_id      = out_rec.window_id;
	assign out_window_type    = out_rec.window_type;
	assign out_host_window_id = out_rec.host_window_id;
	assign out_host_status    = out_rec.host_status;
	assign out_host_type      = out_rec.host_type;
	assign out_host_start     = out_rec.host_start;

endmodule

`default_nettype wire

>>> hw/rtl/skti_checker.sv
// Port-level checker of the sorted keyed table and its bind to the top level.
`default_nettype none

`include "sorted_keyed_table_insert_assert.svh"

module skti_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic existed,
	input logic table_full
);

	// An accepted transaction keeps the block busy in the next cycle.
	`SKTI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after a transaction was accepted")

	// A result lasts one cycle and never follows another directly.
	`SKTI_ASSERT_NEXT(a_done_single, done, !done, "done high in two consecutive cycles")

	// The result is shown only once the block is free again.
	`SKTI_ASSERT(a_done_idle, !done || !busy, "done high while busy")

	// A refused insert never reports an existing key.
	`SKTI_ASSERT(a_full_excl, !(done && existed && table_full), "existed and table_full both set")

endmodule

bind sorted_keyed_table_insert skti_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.existed    (existed),
	.table_full (table_full)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the sorted keyed table: directed and random transactions against a behavioral table.
`timescale 1ns / 1ps

import skti_pkg::*;

// One command transaction as presented on the input ports.
typedef struct packed {
	kind_t      kind;
	logic [5:0] read_index;
	rec_t       rec;
} table_cmd_t;

// One result as shown on the output ports.
typedef struct packed {
	logic [6:0] slot;
	logic       existed;
	logic       table_full;
	logic [6:0] entry_count;
	rec_t       rec;
} table_reply_t;

// Keeps its own sorted table and the replies that the block still owes.
class window_table_tracker;
	rec_t         entries[TABLE_DEPTH_DEF];
	int unsigned  count;
	table_reply_t pending_replies[$];
	int unsigned  mismatches;

	function new();
		count = 0;
		mismatches = 0;
	endfunction

	// Records order by host id, then start time, then window id, all unsigned.
	static function logic [159:0] key_of(rec_t r);
		return {r.host_id, r.win_start, r.window_id};
	endfunction

	// Applies an accepted transaction to the table and queues the reply it must produce.
	function void note_command(table_cmd_t c);
		table_reply_t r;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		logic [159:0] k;
		r = '0;
		k = key_of(c.rec);
		case (c.kind)
			KIND_CLEAR: begin
				count = 0;
			end
			KIND_READ: begin
				r.slot = 7'(c.read_index);
				if (c.read_index < count) begin
					r.existed = 1'b1;
					r.rec = entries[c.read_index];
				end
			end
			KIND_INSERT: begin
				// Lowest slot whose key is not below the new key.
				lo = 0;
				hi = count;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (key_of(entries[mid]) < k) lo = mid + 1;
					else hi = mid;
				end
				r.slot = 7'(lo);
				if (lo < count && key_of(entries[lo]) == k) begin
					r.existed = 1'b1;
					r.rec = entries[lo];
				end else if (count >= TABLE_DEPTH_DEF) begin
					r.table_full = 1'b1;
				end else begin
					for (int unsigned i = count; i > lo; i--) entries[i] = entries[i - 1];
					entries[lo] = c.rec;
					count++;
					r.rec = c.rec;
				end
			end
			KIND_NOP: begin
			end
		endcase
		r.entry_count = 7'(count);
		pending_replies.push_back(r);
	endfunction

	function void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	// Compares a shown result with the oldest reply still owed.
	function void check_reply(table_reply_t got);
		table_reply_t want;
		if (pending_replies.size() == 0) begin
			$error("done: result shown with no transaction pending");
			mismatches++;
			return;
		end
		want = pending_replies.pop_front();
		check_field("slot", 64'(want.slot), 64'(got.slot));
		check_field("existed", 64'(want.existed), 64'(got.existed));
		check_field("table_full", 64'(want.table_full), 64'(got.table_full));
		check_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
		check_field("out_host_id", want.rec.host_id, got.rec.host_id);
		check_field("out_win_start", 64'(want.rec.win_start), 64'(got.rec.win_start));
		check_field("out_window_id", want.rec.window_id, got.rec.window_id);
		check_field("out_window_type", 64'(want.rec.window_type),
			64'(got.rec.window_type));
		check_field("out_host_window_id", want.rec.host_window_id, got.rec.host_window_id);
		check_field("out_host_status", 64'(want.rec.host_status),
			64'(got.rec.host_status));
		check_field("out_host_type", 64'(want.rec.host_type), 64'(got.rec.host_type));
		check_field("out_host_start", 64'(want.rec.host_start), 64'(got.rec.host_start));
	endfunction
endclass

module testbench;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned ITEM_TARGET = 1800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = '0;
	logic [5:0]  read_index = '0;
	logic [63:0] host_id = '0;
	logic [31:0] win_start = '0;
	logic [63:0] window_id = '0;
	logic        window_type = 1'b0;
	logic [63:0] host_window_id = '0;
	logic        host_status = 1'b0;
	logic        host_type = 1'b0;
	logic [31:0] host_start = '0;
	logic        done;
	logic [6:0]  slot;
	logic        existed;
	logic        table_full;
	logic [6:0]  entry_count;
	logic [63:0] out_host_id;
	logic [31:0] out_win_start;
	logic [63:0] out_window_id;
	logic        out_window_type;
	logic [63:0] out_host_window_id;
	logic        out_host_status;
	logic        out_host_type;
	logic [31:0] out_host_start;

	window_table_tracker tracker;
	table_reply_t        seen_reply;
	int unsigned         cycles = 0;
	int unsigned         sent = 0;
	int unsigned         idle_pct = 0;

	sorted_keyed_table_insert dut (.*);

	always #4 clk = ~clk;

	// Gives up on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	assign seen_reply = {slot, existed, table_full, entry_count, out_host_id, out_win_start,
		out_window_id, out_host_window_id, out_host_start, out_host_type, out_host_status,
		out_window_type};

	// Every strobed result is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) tracker.check_reply(seen_reply);
	end

	// Holds start low for a random number of cycles at the current idle rate.
	task automatic idle_gap();
		int unsigned n;
		n = 0;
		while ($urandom_range(99) < idle_pct) n++;
		if (idle_pct != 0 && $urandom_range(19) == 0) n += $urandom_range(90);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Presents one transaction and waits for the block to take it.
	task automatic send_cmd(table_cmd_t c);
		idle_gap();
		start          <= 1'b1;
		kind           <= c.kind;
		read_index     <= c.read_index;
		host_id        <= c.rec.host_id;
		win_start      <= c.rec.win_start;
		window_id      <= c.rec.window_id;
		window_type    <= c.rec.window_type;
		host_window_id <= c.rec.host_window_id;
		host_status    <= c.rec.host_status;
		host_type      <= c.rec.host_type;
		host_start     <= c.rec.host_start;
		do @(posedge clk); while (busy);
		tracker.note_command(c);
		if (c.kind != KIND_NOP) sent++;
	endtask

	// Key parts come often from a tiny pool so that ties push the compare to later parts.
	function automatic logic [63:0] pick_part();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2, 3: return 64'($urandom_range(3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic rec_t random_rec();
		rec_t r;
		r.host_id        = pick_part();
		r.win_start      = 32'(pick_part());
		r.window_id      = pick_part();
		r.host_window_id = {$urandom, $urandom};
		r.host_start     = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom);
		r.host_type      = 1'($urandom);
		r.host_status    = 1'($urandom);
		r.window_type    = 1'($urandom);
		return r;
	endfunction

	function automatic table_cmd_t key_cmd(kind_t k, logic [63:0] h, logic [31:0] s,
		logic [63:0] w, logic pay);
		table_cmd_t c;
		c.kind = k;
		c.read_index = '0;
		c.rec = {$bits(rec_t){pay}};
		c.rec.host_id = h;
		c.rec.win_start = s;
		c.rec.window_id = w;
		return c;
	endfunction

	function automatic table_cmd_t noise_cmd(kind_t k, logic [5:0] idx);
		table_cmd_t c;
		c.kind = k;
		c.read_index = idx;
		c.rec = random_rec();
		return c;
	endfunction

	// Random transaction; while filling, new keys dominate so the table reaches its limit.
	function automatic table_cmd_t random_cmd(bit filling);
		table_cmd_t  c;
		rec_t        stored;
		int unsigned roll;
		c = noise_cmd(KIND_INSERT, 6'($urandom));
		roll = $urandom_range(99);
		if (filling) begin
			if (roll < 10) c.kind = KIND_READ;
			else if (roll >= 20) roll = 99;
		end else if (roll < 3) begin
			c.kind = KIND_NOP;
		end else if (roll < 4) begin
			c.kind = KIND_CLEAR;
		end else if (roll < 25) begin
			c.kind = KIND_READ;
		end
		if (c.kind == KIND_READ) begin
			if (tracker.count != 0 && $urandom_range(3) != 0)
				c.read_index = 6'($urandom_range(tracker.count - 1));
		end else if (c.kind == KIND_INSERT && roll < 60 && tracker.count != 0) begin
			// Reuse a stored key with a fresh payload, or step just beside it.
			stored = tracker.entries[$urandom_range(tracker.count - 1)];
			c.rec.host_id = stored.host_id;
			c.rec.win_start = stored.win_start;
			c.rec.window_id = stored.window_id;
			if (roll >= 45) c.rec.window_id = stored.window_id + ($urandom_range(1) ? 64'd1 : '1);
		end
		return c;
	endfunction

	initial begin
		bit          filling;
		int unsigned episode;
		int unsigned phase;
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty reads, ignored kind, key extremes, ordering on each key part.
		send_cmd(noise_cmd(KIND_READ, 6'd0));
		send_cmd(key_cmd(KIND_NOP, '1, '1, '1, 1'b1));
		send_cmd(key_cmd(KIND_INSERT, '1, '1, '1, 1'b1));
		send_cmd(key_cmd(KIND_INSERT, '0, '0, '0, 1'b0));
		send_cmd(key_cmd(KIND_INSERT, '1, '1, '1, 1'b0));
		send_cmd(key_cmd(KIND_INSERT, 64'd2, 32'd0, '1, 1'b1));
		send_cmd(key_cmd(KIND_INSERT, 64'd2, 32'd1, 64'd0, 1'b0));
		send_cmd(key_cmd(KIND_INSERT, 64'd2, 32'd0, 64'd5, 1'b1));
		send_cmd(key_cmd(KIND_INSERT, 64'd1, '1, '1, 1'b0));
		send_cmd(key_cmd(KIND_INSERT, 64'd2, 32'd1, 64'd1, 1'b1));
		send_cmd(key_cmd(KIND_INSERT, 64'd2, 32'd0, 64'd5, 1'b0));
		send_cmd(noise_cmd(KIND_READ, 6'd0));
		send_cmd(noise_cmd(KIND_READ, 6'd3));
		send_cmd(noise_cmd(KIND_READ, 6'd7));
		send_cmd(noise_cmd(KIND_READ, 6'd8));
		send_cmd(noise_cmd(KIND_READ, '1));
		send_cmd(noise_cmd(KIND_NOP, '1));
		send_cmd(noise_cmd(KIND_CLEAR, '1));
		send_cmd(noise_cmd(KIND_READ, 6'd0));
		send_cmd(key_cmd(KIND_INSERT, 64'd2, 32'd0, 64'd5, 1'b1));
		send_cmd(noise_cmd(KIND_READ, 6'd0));
		send_cmd(noise_cmd(KIND_READ, 6'd1));

		// Random part in episodes, each from an empty table; idle rate moves through phases.
		episode = 0;
		while (sent < ITEM_TARGET) begin
			phase = sent * 4 / ITEM_TARGET;
			case (phase)
				1: idle_pct = 76;
				3: idle_pct = 32;
				default: idle_pct = 0;
			endcase
			filling = (episode == 0) || ($urandom_range(3) == 0);
			send_cmd(noise_cmd(KIND_CLEAR, 6'($urandom)));
			repeat (filling ? 120 : $urandom_range(10, 80)) send_cmd(random_cmd(filling));
			episode++;
		end
		start <= 1'b0;

		// Drain the outstanding result, then allow one full insert time for strays.
		while (tracker.pending_replies.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (tracker.mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
